### rtl/kdct_pkg.sv
`default_nettype none

package kdct_pkg;

   localparam int TABLE_SLOTS_DEFAULT = 4;

   localparam int DEPTH_W = 32;
   localparam int TAG_W   = 32;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 3;
   localparam int KIND_W  = 2;

   // request kinds; the fourth code is unused and does nothing
   typedef enum logic [KIND_W-1:0] {
      KIND_ADD    = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_READ   = 2'd2
   } kind_type;

endpackage

`default_nettype wire

### rtl/kdct_ram.sv
`default_nettype none

module kdct_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/keep_deepest_contacts_table.sv
`default_nettype none

// Keeps up to TABLE_SLOTS contacts (signed Q16.16 depth plus a 32-bit tag),
// retaining the deepest ones once the table is full.
// Request channel (req_*): kind 0 adds a contact, 1 removes the entry at
// slot_index (last entry moves into the hole), 2 reads the entry at
// slot_index. Every request gives exactly one word on the rsp_* channel.
// Requests are handled one at a time; req_stall is high while one is in
// flight. An add into a full table first finds the lowest depth; one entry
// per cycle goes through the shared signed comparator during that search.
// The entries sit in a small RAM with one read and one write port.
// A finished word is held in the output register while rsp_stall is high;
// the block takes the next request meanwhile and completes it once the
// output register drains.
// Reset (synchronous) empties the table and drops any pending word; entry
// contents are not cleared, only entries below the count are ever read.
module keep_deepest_contacts_table
   import kdct_pkg::*;
#(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [KIND_W-1:0]         req_kind,
   input  wire logic signed [DEPTH_W-1:0] req_contact_depth,
   input  wire logic [TAG_W-1:0]          req_contact_tag,
   input  wire logic [SLOT_W-1:0]         req_slot_index,

   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_accepted,
   output logic [SLOT_W-1:0]              rsp_slot_used,
   output logic [COUNT_W-1:0]             rsp_count_after,
   output logic signed [DEPTH_W-1:0]      rsp_read_depth,
   output logic [TAG_W-1:0]               rsp_read_tag
);

   localparam int IDX_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
   localparam int WORD_W = DEPTH_W + TAG_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_PICK,
      S_MOVE,
      S_FETCH,
      S_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0]          scan_ff, scan_in;
   logic [IDX_W-1:0]          min_idx_ff, min_idx_in;
   logic signed [DEPTH_W-1:0] min_ff, min_in;
   logic [IDX_W-1:0]          slot_ff, slot_in;
   logic signed [DEPTH_W-1:0] depth_ff, depth_in;
   logic [TAG_W-1:0]          tag_ff, tag_in;

   logic                      res_acc_ff, res_acc_in;
   logic [SLOT_W-1:0]         res_slot_ff, res_slot_in;
   logic signed [DEPTH_W-1:0] res_depth_ff, res_depth_in;
   logic [TAG_W-1:0]          res_tag_ff, res_tag_in;

   logic                      rsp_acc_ff, rsp_acc_in;
   logic [SLOT_W-1:0]         rsp_slot_ff, rsp_slot_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic signed [DEPTH_W-1:0] rsp_depth_ff, rsp_depth_in;
   logic [TAG_W-1:0]          rsp_tag_ff, rsp_tag_in;

   logic                      ram_wr_en;
   logic [IDX_W-1:0]          ram_wr_addr;
   logic [WORD_W-1:0]         ram_wr_data;
   logic [IDX_W-1:0]          ram_rd_addr;
   logic [WORD_W-1:0]         ram_rd_data;
   logic signed [DEPTH_W-1:0] rd_depth;
   logic [TAG_W-1:0]          rd_tag;

   logic signed [DEPTH_W-1:0] cmp_a, cmp_b;
   logic                      cmp_lt;

   logic                      accept;
   logic                      out_free;
   logic                      slot_ok;
   logic                      has_room;
   logic [CNT_W-1:0]          count_m1;
   logic [31:0]               count_wide;

   kdct_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_depth = ram_rd_data[WORD_W-1:TAG_W];
   assign rd_tag   = ram_rd_data[TAG_W-1:0];

   // one signed comparator, shared by the min scan and the final decision
   assign cmp_lt = cmp_a < cmp_b;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign slot_ok   = 32'(req_slot_index) < 32'(count_ff);
   assign has_room  = count_ff < CNT_W'(TABLE_SLOTS);
   assign count_m1  = count_ff - 1'b1;
   assign count_wide = 32'(count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      min_idx_in   = min_idx_ff;
      min_in       = min_ff;
      slot_in      = slot_ff;
      depth_in     = depth_ff;
      tag_in       = tag_ff;
      res_acc_in   = res_acc_ff;
      res_slot_in  = res_slot_ff;
      res_depth_in = res_depth_ff;
      res_tag_in   = res_tag_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_count_in = rsp_count_ff;
      rsp_depth_in = rsp_depth_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      ram_wr_en   = 1'b0;
      ram_wr_addr = slot_ff;
      ram_wr_data = {depth_ff, tag_ff};
      ram_rd_addr = '0;
      cmp_a       = rd_depth;
      cmp_b       = min_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               depth_in     = req_contact_depth;
               tag_in       = req_contact_tag;
               slot_in      = req_slot_index[IDX_W-1:0];
               res_acc_in   = 1'b0;
               res_slot_in  = '0;
               res_depth_in = '0;
               res_tag_in   = '0;
               state_in     = S_FINISH;
               case (req_kind)
                  KIND_ADD: begin
                     if (has_room) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = count_ff[IDX_W-1:0];
                        ram_wr_data = {req_contact_depth, req_contact_tag};
                        res_acc_in  = 1'b1;
                        res_slot_in = SLOT_W'(count_ff[IDX_W-1:0]);
                        count_in    = count_ff + 1'b1;
                     end else begin
                        // entry 0 is being read now
                        scan_in  = '0;
                        state_in = S_SCAN;
                     end
                  end
                  KIND_REMOVE: begin
                     res_slot_in = req_slot_index;
                     if (slot_ok) begin
                        ram_rd_addr = count_m1[IDX_W-1:0];
                        state_in    = S_MOVE;
                     end
                  end
                  KIND_READ: begin
                     res_slot_in = req_slot_index;
                     if (slot_ok) begin
                        ram_rd_addr = req_slot_index[IDX_W-1:0];
                        state_in    = S_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SCAN: begin
            // strict less keeps the lowest-numbered entry on ties
            if (scan_ff == '0 || cmp_lt) begin
               min_in     = rd_depth;
               min_idx_in = scan_ff;
            end
            if (scan_ff == IDX_W'(TABLE_SLOTS - 1)) begin
               state_in = S_PICK;
            end else begin
               ram_rd_addr = scan_ff + 1'b1;
               scan_in     = scan_ff + 1'b1;
            end
         end

         S_PICK: begin
            cmp_a = min_ff;
            cmp_b = depth_ff;
            if (cmp_lt) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = min_idx_ff;
               res_acc_in  = 1'b1;
               res_slot_in = SLOT_W'(min_idx_ff);
            end
            state_in = S_FINISH;
         end

         S_MOVE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = slot_ff;
            ram_wr_data = ram_rd_data;
            count_in    = count_m1;
            res_acc_in  = 1'b1;
            state_in    = S_FINISH;
         end

         S_FETCH: begin
            res_acc_in   = 1'b1;
            res_depth_in = rd_depth;
            res_tag_in   = rd_tag;
            state_in     = S_FINISH;
         end

         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = res_acc_ff;
               rsp_slot_in  = res_slot_ff;
               rsp_count_in = count_wide[COUNT_W-1:0];
               rsp_depth_in = res_depth_ff;
               rsp_tag_in   = res_tag_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      min_idx_ff   <= min_idx_in;
      min_ff       <= min_in;
      slot_ff      <= slot_in;
      depth_ff     <= depth_in;
      tag_ff       <= tag_in;
      res_acc_ff   <= res_acc_in;
      res_slot_ff  <= res_slot_in;
      res_depth_ff <= res_depth_in;
      res_tag_ff   <= res_tag_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_count_ff <= rsp_count_in;
      rsp_depth_ff <= rsp_depth_in;
      rsp_tag_ff   <= rsp_tag_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_acc_ff;
   assign rsp_slot_used   = rsp_slot_ff;
   assign rsp_count_after = rsp_count_ff;
   assign rsp_read_depth  = rsp_depth_ff;
   assign rsp_read_tag    = rsp_tag_ff;

endmodule

`default_nettype wire
